>>> design/assert_macros.svh
// Assertion macros shared by the frame receiver modules.
// Include this file inside a module body; it has no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, skipped while reset is asserted.
`define SFPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SFPR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/sfpr_pkg.sv
// Shared types and constants for the sync framed packet receiver.
// No dependencies; imported by every module of the block.
package sfpr_pkg;

    localparam logic [7:0] SYNC0 = 8'h74;  // 't'
    localparam logic [7:0] SYNC1 = 8'h32;  // '2'
    localparam logic [7:0] SYNC2 = 8'h63;  // 'c'
    localparam logic [15:0] SYNC_SUM = 16'({8'h00, SYNC0} + {8'h00, SYNC1} + {8'h00, SYNC2});

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEY_COMMAND      = 2'd0;
    localparam logic [1:0] CFG_CAPTURE_COMMAND  = 2'd1;
    localparam logic [1:0] CFG_CAPTURE_CAPACITY = 2'd2;

    typedef enum logic [2:0] {
        EV_CAPTURE_BYTE = 3'd0,
        EV_KEY_OK       = 3'd1,
        EV_CAPTURE_OK   = 3'd2,
        EV_OTHER_OK     = 3'd3,
        EV_CSUM_ERROR   = 3'd4
    } t_event;

    typedef struct packed {
        logic [7:0]  key_command;
        logic [7:0]  capture_command;
        logic [15:0] capture_capacity;
    } t_cfg;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic        within_capacity;
        logic [7:0]  key_value;
        logic [7:0]  frame_command;
        logic [15:0] payload_total;
    } t_result;

endpackage

>>> design/sfpr_cfg_regs.sv
// Configuration registers of the frame receiver: key and capture command
// codes and the capture capacity. Depends on sfpr_pkg.
module sfpr_cfg_regs
    import sfpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_COMMAND: begin
                    r_cfg.key_command <= i_cfg_data[7:0];
                end
                CFG_CAPTURE_COMMAND: begin
                    r_cfg.capture_command <= i_cfg_data[7:0];
                end
                CFG_CAPTURE_CAPACITY: begin
                    r_cfg.capture_capacity <= i_cfg_data;
                end
                default: begin
                    // Writes to an unused index are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/sfpr_parser.sv
// Frame parser: sync hunt, header, payload and checksum phases, one byte
// per enabled cycle, producing at most one result. Depends on sfpr_pkg.
module sfpr_parser
    import sfpr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_DATA = 2'd2,
        PH_CSUM = 2'd3
    } t_phase;

    t_phase      r_phase,          n_phase;
    logic [1:0]  r_sync_matched,   n_sync_matched;
    logic [1:0]  r_header_count,   n_header_count;
    logic [7:0]  r_command,        n_command;
    logic [7:0]  r_length_low,     n_length_low;
    logic [15:0] r_bytes_left,     n_bytes_left;
    logic [15:0] r_running_sum,    n_running_sum;
    logic [7:0]  r_checksum_low,   n_checksum_low;
    logic        r_checksum_half,  n_checksum_half;
    logic [7:0]  r_first_key_byte, n_first_key_byte;
    logic        r_key_seen,       n_key_seen;
    logic [15:0] r_capture_count,  n_capture_count;

    logic [15:0] sum_plus_byte;
    logic [15:0] received_sum;
    logic [15:0] new_length;
    logic        is_key;
    logic        is_capture;
    logic [1:0]  restart_sync;

    assign sum_plus_byte = r_running_sum + {8'h00, i_byte};
    assign received_sum  = {i_byte, r_checksum_low};
    assign new_length    = {i_byte, r_length_low};
    assign is_key        = (r_command == i_cfg.key_command);
    assign is_capture    = (r_command == i_cfg.capture_command);
    // A wrong byte that is itself 't' starts a new sync match.
    assign restart_sync  = (i_byte == SYNC0) ? 2'd1 : 2'd0;

    always_comb begin
        n_phase          = r_phase;
        n_sync_matched   = r_sync_matched;
        n_header_count   = r_header_count;
        n_command        = r_command;
        n_length_low     = r_length_low;
        n_bytes_left     = r_bytes_left;
        n_running_sum    = r_running_sum;
        n_checksum_low   = r_checksum_low;
        n_checksum_half  = r_checksum_half;
        n_first_key_byte = r_first_key_byte;
        n_key_seen       = r_key_seen;
        n_capture_count  = r_capture_count;
        o_res_valid      = 1'b0;
        o_res            = '0;

        if (i_en) begin
            case (r_phase)
                PH_HUNT: begin
                    case (r_sync_matched)
                        2'd0: begin
                            n_sync_matched = restart_sync;
                        end
                        2'd1: begin
                            n_sync_matched = (i_byte == SYNC1) ? 2'd2 : restart_sync;
                        end
                        default: begin
                            if (i_byte == SYNC2) begin
                                n_sync_matched = 2'd0;
                                n_running_sum  = SYNC_SUM;
                                n_header_count = 2'd0;
                                n_phase        = PH_HEAD;
                            end else begin
                                n_sync_matched = restart_sync;
                            end
                        end
                    endcase
                end
                PH_HEAD: begin
                    n_running_sum = sum_plus_byte;
                    case (r_header_count)
                        2'd0: begin
                            n_command      = i_byte;
                            n_header_count = 2'd1;
                        end
                        2'd1: begin
                            n_length_low   = i_byte;
                            n_header_count = 2'd2;
                        end
                        default: begin
                            n_bytes_left     = new_length;
                            n_header_count   = 2'd0;
                            n_capture_count  = '0;
                            n_key_seen       = 1'b0;
                            n_first_key_byte = '0;
                            if (new_length == '0) begin
                                n_phase         = PH_CSUM;
                                n_checksum_half = 1'b0;
                                n_checksum_low  = '0;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    endcase
                end
                PH_DATA: begin
                    n_running_sum = sum_plus_byte;
                    // The key code wins when both codes are equal.
                    if (is_key) begin
                        if (!r_key_seen) begin
                            n_first_key_byte = i_byte;
                            n_key_seen       = 1'b1;
                        end
                    end else if (is_capture) begin
                        o_res_valid           = 1'b1;
                        o_res.event_res       = EV_CAPTURE_BYTE;
                        o_res.payload_byte    = i_byte;
                        o_res.byte_index      = r_capture_count;
                        o_res.within_capacity = (r_capture_count < i_cfg.capture_capacity);
                        n_capture_count       = r_capture_count + 16'd1;
                    end
                    n_bytes_left = r_bytes_left - 16'd1;
                    if (r_bytes_left == 16'd1) begin
                        n_phase         = PH_CSUM;
                        n_checksum_half = 1'b0;
                        n_checksum_low  = '0;
                    end
                end
                default: begin
                    if (!r_checksum_half) begin
                        n_checksum_low  = i_byte;
                        n_checksum_half = 1'b1;
                    end else begin
                        o_res_valid         = 1'b1;
                        o_res.frame_command = r_command;
                        o_res.payload_total = r_capture_count;
                        if (received_sum != r_running_sum) begin
                            o_res.event_res = EV_CSUM_ERROR;
                        end else if (is_key) begin
                            o_res.event_res = EV_KEY_OK;
                            o_res.key_value = r_key_seen ? r_first_key_byte : 8'h00;
                        end else if (is_capture) begin
                            o_res.event_res = EV_CAPTURE_OK;
                        end else begin
                            o_res.event_res = EV_OTHER_OK;
                        end
                        n_phase         = PH_HUNT;
                        n_sync_matched  = 2'd0;
                        n_checksum_half = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HUNT;
            r_sync_matched   <= '0;
            r_header_count   <= '0;
            r_command        <= '0;
            r_length_low     <= '0;
            r_bytes_left     <= '0;
            r_running_sum    <= '0;
            r_checksum_low   <= '0;
            r_checksum_half  <= 1'b0;
            r_first_key_byte <= '0;
            r_key_seen       <= 1'b0;
            r_capture_count  <= '0;
        end else begin
            r_phase          <= n_phase;
            r_sync_matched   <= n_sync_matched;
            r_header_count   <= n_header_count;
            r_command        <= n_command;
            r_length_low     <= n_length_low;
            r_bytes_left     <= n_bytes_left;
            r_running_sum    <= n_running_sum;
            r_checksum_low   <= n_checksum_low;
            r_checksum_half  <= n_checksum_half;
            r_first_key_byte <= n_first_key_byte;
            r_key_seen       <= n_key_seen;
            r_capture_count  <= n_capture_count;
        end
    end

    `SFPR_ASSERT(a_no_result_while_hunting, i_clk, i_rst_n,
        (r_phase == PH_HUNT) |-> !o_res_valid,
        "result produced during sync hunt")
    `SFPR_ASSERT(a_half_only_in_csum, i_clk, i_rst_n,
        r_checksum_half |-> (r_phase == PH_CSUM),
        "checksum half flag outside checksum phase")
    `SFPR_ASSERT(a_payload_never_empty, i_clk, i_rst_n,
        (r_phase == PH_DATA) |-> (r_bytes_left != '0),
        "payload phase with no bytes left")

endmodule

>>> design/sync_framed_packet_receiver.sv
// Top level of the sync framed packet receiver: input register, parser,
// configuration registers and result register. Depends on sfpr_pkg.
//
//  Channel   Dir  Ports           Contents
//  s_axis    in   tdata[7:0]      rx_byte
//  m_axis    out  tuser[2:0]      event_res
//                 tdata[63:0]     payload_byte .. payload_total
//  cfg       in   i_cfg_*         key_command, capture_command, capture_capacity
//
// A request accepted into the input register is parsed once the output register is
// free, and its result, if any, is registered in the output register; one byte is
// taken every cycle while m_axis_tready does not stall the output.
// Reset is synchronous; it returns the parser to sync hunt and clears the configuration
// registers and both valid flags.
// While a result waits in the output register, the next byte is held in the input
// register and s_axis_tready stays low until m_axis_tready frees the output.
module sync_framed_packet_receiver
    import sfpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [23:8] byte_index, [24] within_capacity,
    // [32:25] key_value, [40:33] frame_command, [56:41] payload_total, rest zero
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] event_res
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    `include "assert_macros.svh"

    t_cfg       cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out_res;
    logic       res_valid;
    t_result    res;
    logic       out_free;
    logic       advance;

    sfpr_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // A held byte only moves on when the result register can take a result.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;

    sfpr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= res_valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (advance && res_valid) begin
            r_out_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_res.event_res;
    assign m_axis_tdata  = {7'b0, r_out_res.payload_total, r_out_res.frame_command,
                            r_out_res.key_value, r_out_res.within_capacity,
                            r_out_res.byte_index, r_out_res.payload_byte};

    `SFPR_ASSERT(a_no_overwrite, i_clk, i_rst_n,
        (r_out_valid && !m_axis_tready) |-> !advance,
        "pending result would be overwritten")
    `SFPR_ASSERT(a_stall_blocks_input, i_clk, i_rst_n,
        (r_in_valid && !out_free) |-> !s_axis_tready,
        "input taken while held byte is stalled")
    `SFPR_ASSERT(a_end_fields_clear, i_clk, i_rst_n,
        (m_axis_tvalid && (m_axis_tuser != EV_CAPTURE_BYTE)) |-> (m_axis_tdata[24:0] == '0),
        "frame end result carries capture fields")

endmodule

>>> sim/sync_framed_packet_receiver_tb.sv
// Self-checking testbench for sync_framed_packet_receiver: byte stream in, frame events out.
// Keeps its own frame parser model and checks every result field by field.
// Depends on sfpr_pkg and the sync_framed_packet_receiver RTL.
module sync_framed_packet_receiver_tb;
    import sfpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned END_CYCLES     = 20;
    localparam int unsigned LONG_HOLD      = 200;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_BUDGET   = 75;
    localparam int unsigned RANDOM_PHASES  = 8;

    localparam logic [1:0] CFG_UNMAPPED    = 2'd3;
    localparam logic [7:0] DIR_KEY_CMD     = 8'h4B;
    localparam logic [7:0] DIR_CAPTURE_CMD = 8'h43;
    localparam logic [7:0] DIR_OTHER_CMD   = 8'h00;

    typedef enum logic [1:0] {RX_HUNT, RX_HEADER, RX_PAYLOAD, RX_CHECKSUM} t_rx_state;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] payload_byte, [23:8] byte_index, [24] within_capacity,
    // [32:25] key_value, [40:33] frame_command, [56:41] payload_total
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;           // [2:0] event_res
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = 2'd0;
    logic [15:0] i_cfg_data    = 16'h0000;

    // Parser model state and its copy of the registers.
    t_cfg        cfg_copy      = '0;
    t_rx_state   rx_state      = RX_HUNT;
    logic [1:0]  sync_count    = '0;
    logic [1:0]  header_count  = '0;
    logic [7:0]  frame_cmd     = '0;
    logic [7:0]  len_low       = '0;
    logic [15:0] bytes_left    = '0;
    logic [15:0] frame_sum     = '0;
    logic [7:0]  csum_low      = '0;
    logic        csum_half     = 1'b0;
    logic [7:0]  key_byte      = '0;
    logic        key_seen      = 1'b0;
    logic [15:0] capture_count = '0;

    logic [7:0]  rx_stream[$];
    logic [7:0]  frame_payload[$];
    t_result     expected_events[$];

    int unsigned mismatches    = 0;
    int unsigned idle_pct      = 20;
    bit          no_idle       = 1'b0;
    int unsigned gap_left      = 0;
    int unsigned stall_left    = 0;
    int unsigned hold_left     = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned quiet_cycles  = 0;

    sync_framed_packet_receiver i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Advances the parser model by one received byte; returns 1 when the byte
    // produces an event.
    function automatic bit parse_rx_byte(input logic [7:0] b, output t_result ev);
        logic [15:0] got_sum;
        bit          produced;
        ev       = '0;
        produced = 1'b0;
        case (rx_state)
            RX_HUNT: begin
                if (sync_count == 2'd2 && b == SYNC2) begin
                    sync_count   = '0;
                    frame_sum    = SYNC_SUM;
                    header_count = '0;
                    rx_state     = RX_HEADER;
                end else if (sync_count == 2'd1 && b == SYNC1) begin
                    sync_count = 2'd2;
                end else begin
                    // A stray 't' always restarts the sync search.
                    sync_count = (b == SYNC0) ? 2'd1 : 2'd0;
                end
            end
            RX_HEADER: begin
                frame_sum = frame_sum + {8'h00, b};
                if (header_count == 2'd0) begin
                    frame_cmd    = b;
                    header_count = 2'd1;
                end else if (header_count == 2'd1) begin
                    len_low      = b;
                    header_count = 2'd2;
                end else begin
                    bytes_left    = {b, len_low};
                    header_count  = '0;
                    capture_count = '0;
                    key_seen      = 1'b0;
                    key_byte      = '0;
                    csum_half     = 1'b0;
                    csum_low      = '0;
                    rx_state      = (bytes_left == '0) ? RX_CHECKSUM : RX_PAYLOAD;
                end
            end
            RX_PAYLOAD: begin
                frame_sum = frame_sum + {8'h00, b};
                if (frame_cmd == cfg_copy.key_command) begin
                    if (!key_seen) begin
                        key_byte = b;
                        key_seen = 1'b1;
                    end
                end else if (frame_cmd == cfg_copy.capture_command) begin
                    ev.event_res       = EV_CAPTURE_BYTE;
                    ev.payload_byte    = b;
                    ev.byte_index      = capture_count;
                    ev.within_capacity = (capture_count < cfg_copy.capture_capacity);
                    capture_count      = capture_count + 16'd1;
                    produced           = 1'b1;
                end
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == '0) begin
                    csum_half = 1'b0;
                    csum_low  = '0;
                    rx_state  = RX_CHECKSUM;
                end
            end
            default: begin
                if (!csum_half) begin
                    csum_low  = b;
                    csum_half = 1'b1;
                end else begin
                    got_sum          = {b, csum_low};
                    ev.frame_command = frame_cmd;
                    ev.payload_total = capture_count;
                    if (got_sum != frame_sum) begin
                        ev.event_res = EV_CSUM_ERROR;
                    end else if (frame_cmd == cfg_copy.key_command) begin
                        ev.event_res = EV_KEY_OK;
                        ev.key_value = key_seen ? key_byte : 8'h00;
                    end else if (frame_cmd == cfg_copy.capture_command) begin
                        ev.event_res = EV_CAPTURE_OK;
                    end else begin
                        ev.event_res = EV_OTHER_OK;
                    end
                    rx_state   = RX_HUNT;
                    sync_count = '0;
                    csum_half  = 1'b0;
                    produced   = 1'b1;
                end
            end
        endcase
        return produced;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic logic [7:0] non_sync_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == SYNC0 || b == SYNC1 || b == SYNC2);
        return b;
    endfunction

    function automatic logic [7:0] pick_command();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return cfg_copy.key_command;
        if (r < 70)
            return cfg_copy.capture_command;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        if (r < 95)
            return $urandom_range(7, 20);
        return $urandom_range(21, 40);
    endfunction

    // Queues one frame. Payload bytes already in frame_payload are used first.
    // A corrupted frame has one bit flipped in its payload or checksum; a
    // truncated one stops inside the payload, so the parser eats what follows.
    task automatic push_frame(input logic [7:0] cmd, input int unsigned len,
                              input bit corrupt, input bit truncate);
        logic [7:0]  frame[$];
        logic [15:0] sum;
        logic [15:0] len16;
        int unsigned k;
        int unsigned keep;
        len16 = 16'(len);
        frame = '{SYNC0, SYNC1, SYNC2, cmd, len16[7:0], len16[15:8]};
        while (frame_payload.size() < len) begin
            if ($urandom_range(0, 15) == 0)
                frame_payload.push_back($urandom_range(0, 1) ? SYNC0 : SYNC2);
            else
                frame_payload.push_back(8'($urandom_range(0, 255)));
        end
        for (k = 0; k < len; k++)
            frame.push_back(frame_payload[k]);
        frame_payload.delete();
        if (truncate && len != 0) begin
            keep = 6 + $urandom_range(0, len - 1);
            while (frame.size() > keep)
                void'(frame.pop_back());
        end else begin
            sum = '0;
            foreach (frame[i])
                sum = sum + {8'h00, frame[i]};
            frame.push_back(sum[7:0]);
            frame.push_back(sum[15:8]);
            if (corrupt) begin
                k = $urandom_range(6, frame.size() - 1);
                frame[k] = frame[k] ^ 8'(1 << $urandom_range(0, 7));
            end
        end
        foreach (frame[i])
            rx_stream.push_back(frame[i]);
    endtask

    // Line noise; every fragment ends on a byte outside the sync word.
    task automatic push_noise(input int unsigned fragments);
        int unsigned n;
        for (n = 0; n < fragments; n++) begin
            case ($urandom_range(0, 3))
                0: ;
                1: rx_stream.push_back(SYNC0);
                2: begin
                    rx_stream.push_back(SYNC0);
                    rx_stream.push_back(SYNC1);
                end
                default: begin
                    rx_stream.push_back(SYNC0);
                    rx_stream.push_back(SYNC0);
                    rx_stream.push_back(SYNC1);
                end
            endcase
            rx_stream.push_back(non_sync_byte());
        end
    endtask

    task automatic push_random_traffic(input int unsigned budget);
        int unsigned start;
        int unsigned r;
        int unsigned len;
        start = rx_stream.size();
        while (rx_stream.size() - start < budget) begin
            r   = $urandom_range(0, 99);
            len = pick_length();
            if (r < 10)
                push_noise($urandom_range(1, 4));
            else if (r < 15 && len != 0)
                push_frame(pick_command(), len, 1'b0, 1'b1);
            else
                push_frame(pick_command(), len, r < 27, 1'b0);
        end
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        case (index)
            CFG_KEY_COMMAND:      cfg_copy.key_command      = value[7:0];
            CFG_CAPTURE_COMMAND:  cfg_copy.capture_command  = value[7:0];
            CFG_CAPTURE_CAPACITY: cfg_copy.capture_capacity = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every queued byte is taken and every event has come back,
    // then lets bytes that produce nothing clear the pipeline.
    task automatic wait_until_drained();
        while (rx_stream.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Byte sender; the model advances on every accepted request.
    always @(posedge i_clk) begin
        t_result outcome;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (parse_rx_byte(s_axis_tdata, outcome))
                    expected_events.push_back(outcome);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (rx_stream.size() != 0) begin
                    if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
                        gap_left = $urandom_range(1, 9) - 1;
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        s_axis_tvalid <= 1'b1;
                        s_axis_tdata  <= rx_stream.pop_front();
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Event receiver and checker.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_events.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected event, expected none, actual event %0d data %h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(m_axis_tuser));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(m_axis_tdata[7:0]));
                    check_field("byte_index", 32'(want.byte_index),
                                32'(m_axis_tdata[23:8]));
                    check_field("within_capacity", 32'(want.within_capacity),
                                32'(m_axis_tdata[24]));
                    check_field("key_value", 32'(want.key_value),
                                32'(m_axis_tdata[32:25]));
                    check_field("frame_command", 32'(want.frame_command),
                                32'(m_axis_tdata[40:33]));
                    check_field("payload_total", 32'(want.payload_total),
                                32'(m_axis_tdata[56:41]));
                end
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned ph;
        logic [7:0]  key_cmd;
        logic [7:0]  cap_cmd;
        logic [15:0] capacity;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames: restart on a stray 't', a key frame with the top byte
        // value, a capture frame crossing capacity, an empty frame with a bad checksum.
        write_reg(CFG_KEY_COMMAND, {8'h00, DIR_KEY_CMD});
        write_reg(CFG_CAPTURE_COMMAND, {8'h00, DIR_CAPTURE_CMD});
        write_reg(CFG_CAPTURE_CAPACITY, 16'd1);
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        rx_stream.push_back(SYNC0);
        frame_payload.push_back(8'hFF);
        push_frame(DIR_KEY_CMD, 1, 1'b0, 1'b0);
        frame_payload.push_back(8'h00);
        frame_payload.push_back(8'h80);
        push_frame(DIR_CAPTURE_CMD, 2, 1'b0, 1'b0);
        push_frame(DIR_OTHER_CMD, 0, 1'b1, 1'b0);
        wait_until_drained();

        for (ph = 1; ph <= RANDOM_PHASES; ph++) begin
            key_cmd  = 8'($urandom_range(0, 255));
            cap_cmd  = ($urandom_range(0, 3) == 0) ? key_cmd : 8'($urandom_range(0, 255));
            capacity = 16'($urandom_range(0, 12));
            case (ph)
                1: begin
                    key_cmd  = 8'h00;
                    cap_cmd  = 8'hFF;
                    capacity = 16'h0000;
                end
                2: begin
                    key_cmd  = 8'hFF;
                    cap_cmd  = 8'h00;
                    capacity = 16'hFFFF;
                end
                3: cap_cmd = key_cmd;
                4: begin
                    cap_cmd  = ~key_cmd;
                    capacity = 16'd280;
                end
                default: ;
            endcase
            idle_pct <= (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 15 : 35);
            no_idle  <= (ph >= RANDOM_PHASES - 1);
            // Upper data bits are don't-care for the byte-wide registers.
            write_reg(CFG_KEY_COMMAND, {8'($urandom_range(0, 255)), key_cmd});
            write_reg(CFG_CAPTURE_COMMAND, {8'($urandom_range(0, 255)), cap_cmd});
            write_reg(CFG_CAPTURE_CAPACITY, capacity);
            if (ph == 4) begin
                // Long receiver hold while a long capture frame keeps arriving,
                // so the input side has to back up.
                hold_requests <= hold_requests + 1;
                push_frame(cap_cmd, 300, 1'b0, 1'b0);
            end
            push_random_traffic(PHASE_BUDGET);
            wait_until_drained();
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
